/* hw/rtl/catmull_rom_spline_tessellator_defines.svh */
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator assertion macros
// Concurrent check helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_SPLINE_TESSELLATOR_DEFINES_SVH
`define CATMULL_ROM_SPLINE_TESSELLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CRST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("crst check failed");
`define CRST_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("crst forbidden condition");
`else
`define CRST_ASSERT(lbl, clk, rstn, prop)
`define CRST_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* hw/rtl/crst_pkg.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator package
// Shared types, constants and helpers.
// ----------------------------------------------------------------------------
package crst_pkg;

  localparam int unsigned MaxSegPoints = 64;
  localparam int unsigned CoordW       = 24;
  localparam int unsigned TotalW       = 12;
  localparam int unsigned CountW       = 9;
  localparam int unsigned ShareSteps   = 12;
  localparam int unsigned DivSteps     = 17;
  localparam int unsigned Taps         = 4;

  localparam logic [0:0] RegTotal = 1'b0;
  localparam logic [0:0] RegCount = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SHARE, ST_SEG, ST_CHK, ST_MUL1, ST_MUL2, ST_NUM,
    ST_DINIT, ST_DIV, ST_MAC, ST_OUT, ST_SHIFT
  } state_e;

  typedef struct packed {
    logic       load_in;
    logic       share_init;
    logic       share_step;
    logic       seg_setup;
    logic       mul1;
    logic       mul2;
    logic       num;
    logic       div_init;
    logic       div_step;
    logic       mac_step;
    logic       mac_first;
    logic [1:0] mac_idx;
    logic       out_load;
    logic       k_next;
    logic       shift;
  } cmd_t;

  typedef struct packed {
    logic curve_first;
    logic seg_active;
    logic n_zero;
    logic k_last;
    logic out_free;
  } sts_t;

  function automatic logic [CoordW-1:0] sat24(input logic signed [27:0] v);
    logic [CoordW-1:0] r;
    if (v > 28'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -28'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/crst_ctrl.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator controller
// Sequences share division, segment setup and the per-point evaluation.
// ----------------------------------------------------------------------------
module crst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  crst_pkg::sts_t sts_i,
  output crst_pkg::cmd_t cmd_o
);

  crst_pkg::state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crst_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      crst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d = '0;
          if (sts_i.curve_first) begin
            cmd_o.share_init = 1'b1;
            state_d = crst_pkg::ST_SHARE;
          end else begin
            state_d = crst_pkg::ST_SEG;
          end
        end
      end
      crst_pkg::ST_SHARE: begin
        cmd_o.share_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(crst_pkg::ShareSteps - 1)) begin
          state_d = crst_pkg::ST_SEG;
        end
      end
      crst_pkg::ST_SEG: begin
        if (sts_i.seg_active) begin
          cmd_o.seg_setup = 1'b1;
          state_d = crst_pkg::ST_CHK;
        end else begin
          state_d = crst_pkg::ST_SHIFT;
        end
      end
      crst_pkg::ST_CHK: begin
        state_d = sts_i.n_zero ? crst_pkg::ST_SHIFT : crst_pkg::ST_MUL1;
      end
      crst_pkg::ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = crst_pkg::ST_MUL2;
      end
      crst_pkg::ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = crst_pkg::ST_NUM;
      end
      crst_pkg::ST_NUM: begin
        cmd_o.num = 1'b1;
        state_d = crst_pkg::ST_DINIT;
      end
      crst_pkg::ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d = '0;
        state_d = crst_pkg::ST_DIV;
      end
      crst_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(crst_pkg::DivSteps - 1)) begin
          cnt_d = '0;
          state_d = crst_pkg::ST_MAC;
        end
      end
      crst_pkg::ST_MAC: begin
        cmd_o.mac_step  = 1'b1;
        cmd_o.mac_first = (cnt_q == 5'd0);
        cmd_o.mac_idx   = cnt_q[1:0];
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(crst_pkg::Taps - 1)) begin
          state_d = crst_pkg::ST_OUT;
        end
      end
      crst_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.k_last) begin
            state_d = crst_pkg::ST_SHIFT;
          end else begin
            cmd_o.k_next = 1'b1;
            state_d = crst_pkg::ST_MUL1;
          end
        end
      end
      crst_pkg::ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d = crst_pkg::ST_IDLE;
      end
      default: state_d = crst_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/crst_dp.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator datapath
// Window, budget, weight divider, multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module crst_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [11:0]           cfg_wdata_i,
  input  logic [23:0]           cp_x_i,
  input  logic [23:0]           cp_y_i,
  input  crst_pkg::cmd_t        cmd_i,
  output crst_pkg::sts_t        sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [23:0]           out_x_o,
  output logic [23:0]           out_y_o,
  output logic [7:0]            seg_o,
  output logic                  last_o,
  output logic                  clip_o
);

  logic [11:0] total_q;
  logic [8:0]  count_q;
  logic signed [23:0] wx_q [4];
  logic signed [23:0] wy_q [4];
  logic [8:0]  pts_q;
  logic [11:0] budget_q;
  logic [11:0] sdiv_q;
  logic [7:0]  srem_q;
  logic [6:0]  n_q;
  logic [5:0]  k_q;
  logic        clip_q;
  logic [7:0]  seg_q;
  logic [11:0] k2_q;
  logic [12:0] n2_q, kn_q;
  logic [18:0] k3_q, k2n_q, kn2_q, n3_q;
  logic [19:0] mag_q [4];
  logic        neg_q [4];
  logic [19:0] rem_q [4];
  logic [16:0] dvd_q [4];
  logic signed [43:0] accx_q, accy_q;
  logic        ovalid_q;
  logic [23:0] ox_q, oy_q;
  logic [7:0]  oseg_q;
  logic        olast_q, oclip_q;

  logic [8:0]  eff;
  logic [7:0]  segs;
  logic [8:0]  srem2;
  logic [8:0]  pnext;
  logic [19:0] den;
  logic signed [22:0] k3s, k2ns, kn2s, n3s;
  logic signed [22:0] num [4];
  logic signed [17:0] w_sel;
  logic signed [23:0] px_sel, py_sel;
  logic signed [41:0] prod_x, prod_y;
  logic signed [43:0] rx, ry;
  logic [6:0]  n_pick;

  always_comb begin
    eff = count_q;
    if (count_q < 9'd4) eff = 9'd4;
    if (count_q > 9'd256) eff = 9'd256;
  end
  assign segs  = 8'(eff - 9'd3);
  assign srem2 = {srem_q, sdiv_q[11]};
  assign pnext = (pts_q + 9'd1 >= eff) ? 9'd0 : pts_q + 9'd1;
  assign den   = {n3_q, 1'b0};

  assign k3s  = 23'(k3_q);
  assign k2ns = 23'(k2n_q);
  assign kn2s = 23'(kn2_q);
  assign n3s  = 23'(n3_q);
  assign num[0] = -k3s + (k2ns <<< 1) - kn2s;
  assign num[1] = (k3s <<< 1) + k3s - (k2ns <<< 2) - k2ns + (n3s <<< 1);
  assign num[2] = -((k3s <<< 1) + k3s) + (k2ns <<< 2) + kn2s;
  assign num[3] = k3s - k2ns;

  assign w_sel  = neg_q[cmd_i.mac_idx] ? -$signed({1'b0, dvd_q[cmd_i.mac_idx]})
                                       : $signed({1'b0, dvd_q[cmd_i.mac_idx]});
  assign px_sel = wx_q[cmd_i.mac_idx];
  assign py_sel = wy_q[cmd_i.mac_idx];
  assign prod_x = w_sel * px_sel;
  assign prod_y = w_sel * py_sel;
  assign rx = accx_q + 44'sd32768;
  assign ry = accy_q + 44'sd32768;

  always_comb begin
    logic [11:0] sh;
    sh = (budget_q < sdiv_q) ? budget_q : sdiv_q;
    n_pick = (sh > 12'(crst_pkg::MaxSegPoints)) ? 7'(crst_pkg::MaxSegPoints) : sh[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= 12'd64;
      count_q  <= 9'd4;
      pts_q    <= '0;
      budget_q <= 12'd64;
      sdiv_q   <= 12'd64;
      ovalid_q <= 1'b0;
      for (int j = 0; j < 4; j++) begin
        wx_q[j] <= '0;
        wy_q[j] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          crst_pkg::RegTotal: total_q <= cfg_wdata_i;
          crst_pkg::RegCount: count_q <= cfg_wdata_i[8:0];
          default: ;
        endcase
      end
      if (cmd_i.load_in) begin
        wx_q[3] <= cp_x_i;
        wy_q[3] <= cp_y_i;
      end
      if (cmd_i.share_init) begin
        budget_q <= total_q;
        sdiv_q   <= total_q;
      end
      if (cmd_i.share_step) begin
        sdiv_q <= {sdiv_q[10:0], srem2 >= {1'b0, segs}};
      end
      if (cmd_i.seg_setup && !({sdiv_q, 1'b0} > {1'b0, budget_q})) begin
        budget_q <= budget_q - sdiv_q;
      end
      if (cmd_i.shift) begin
        for (int j = 0; j < 3; j++) begin
          wx_q[j] <= wx_q[j+1];
          wy_q[j] <= wy_q[j+1];
        end
        pts_q <= pnext;
      end
      if (cmd_i.out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.share_init) begin
      srem_q <= '0;
    end
    if (cmd_i.share_step) begin
      srem_q <= (srem2 >= {1'b0, segs}) ? 8'(srem2 - {1'b0, segs}) : srem2[7:0];
    end
    if (cmd_i.seg_setup) begin
      seg_q  <= 8'(pts_q - 9'd3);
      k_q    <= '0;
      if ({sdiv_q, 1'b0} > {1'b0, budget_q}) begin
        clip_q <= budget_q > 12'(crst_pkg::MaxSegPoints);
      end else begin
        clip_q <= sdiv_q > 12'(crst_pkg::MaxSegPoints);
      end
      n_q <= ({sdiv_q, 1'b0} > {1'b0, budget_q})
             ? ((budget_q > 12'(crst_pkg::MaxSegPoints)) ? 7'(crst_pkg::MaxSegPoints)
                                                          : budget_q[6:0])
             : n_pick;
    end
    if (cmd_i.k_next) begin
      k_q <= k_q + 6'd1;
    end
    if (cmd_i.mul1) begin
      k2_q <= k_q * k_q;
      n2_q <= 13'(n_q) * 13'(n_q);
      kn_q <= 13'(k_q) * 13'(n_q);
    end
    if (cmd_i.mul2) begin
      k3_q  <= 19'(k2_q) * 19'(k_q);
      k2n_q <= 19'(k2_q) * 19'(n_q);
      kn2_q <= 19'(kn_q) * 19'(n_q);
      n3_q  <= 19'(n2_q) * 19'(n_q);
    end
    for (int j = 0; j < 4; j++) begin
      if (cmd_i.num) begin
        neg_q[j] <= num[j][22];
        mag_q[j] <= num[j][22] ? 20'(-num[j]) : 20'(num[j]);
      end
      if (cmd_i.div_init) begin
        rem_q[j] <= 20'(({mag_q[j], 16'b0} + 36'(den[19:1])) >> 17);
        dvd_q[j] <= 17'({mag_q[j], 16'b0} + 36'(den[19:1]));
      end
      if (cmd_i.div_step) begin
        if ({rem_q[j], dvd_q[j][16]} >= {1'b0, den}) begin
          rem_q[j] <= 20'({rem_q[j], dvd_q[j][16]} - {1'b0, den});
          dvd_q[j] <= {dvd_q[j][15:0], 1'b1};
        end else begin
          rem_q[j] <= {rem_q[j][18:0], dvd_q[j][16]};
          dvd_q[j] <= {dvd_q[j][15:0], 1'b0};
        end
      end
    end
    if (cmd_i.mac_step) begin
      accx_q <= cmd_i.mac_first ? 44'(prod_x) : accx_q + 44'(prod_x);
      accy_q <= cmd_i.mac_first ? 44'(prod_y) : accy_q + 44'(prod_y);
    end
    if (cmd_i.out_load) begin
      ox_q    <= crst_pkg::sat24($signed(rx[43:16]));
      oy_q    <= crst_pkg::sat24($signed(ry[43:16]));
      oseg_q  <= seg_q;
      olast_q <= (7'(k_q) == n_q - 7'd1);
      oclip_q <= clip_q;
    end
  end

  assign sts_o.curve_first = (pts_q == 9'd0);
  assign sts_o.seg_active  = (pts_q >= 9'd3);
  assign sts_o.n_zero      = (n_q == 7'd0);
  assign sts_o.k_last      = (7'(k_q) == n_q - 7'd1);
  assign sts_o.out_free    = !ovalid_q || out_ready_i;

  assign out_valid_o = ovalid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign seg_o       = oseg_q;
  assign last_o      = olast_q;
  assign clip_o      = oclip_q;

endmodule

/* hw/rtl/catmull_rom_spline_tessellator.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom spline tessellator
// Streams control points in and interpolated curve points out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one control point per transfer (x, y in signed Q16.8).
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write total_points (0) and
//   control_point_count (1); write only while the block is idle.
//   The first three points of a curve only fill the window. Each later point
//   produces a run of up to 64 points on m_axis; tlast marks the final point
//   of the run and tuser flags a clamped share.
//   The first point of a curve runs the 12-step share division. Each
//   output point runs the 17-step restoring divider for the weights and
//   the 4-step multiply-accumulate.
//   One item is handled at a time; s_axis_tready is high only when idle.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset clears the window, the point count and the output valid, and
//   restores total_points 64 and control_point_count 4.
// ----------------------------------------------------------------------------
`include "catmull_rom_spline_tessellator_defines.svh"

module catmull_rom_spline_tessellator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // cp_x, cp_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_x, out_y, segment_index
  output logic        m_axis_tlast,   // last_of_segment
  output logic        m_axis_tuser    // clamped
);

  crst_pkg::cmd_t cmd;
  crst_pkg::sts_t sts;
  logic [23:0] out_x, out_y;
  logic [7:0]  seg_idx;

  crst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cp_x_i      (s_axis_tdata[23:0]),
    .cp_y_i      (s_axis_tdata[47:24]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .seg_o       (seg_idx),
    .last_o      (m_axis_tlast),
    .clip_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {seg_idx, out_y, out_x};

  `CRST_NEVER(a_seg_range, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[55:48] > 8'd252))
  `CRST_ASSERT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `CRST_ASSERT(a_out_from_busy, clk_i, rst_ni, $rose(m_axis_tvalid) |-> !s_axis_tready)

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator testbench
// Streams control points through the block under bursty input and a stalling
// output, predicts every interpolated point in fixed point and compares each
// output transfer field by field. Directed curves come first, then randomized
// curves under a series of budget and count settings.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic [7:0]  seg;
    logic        last;
    logic        clamp;
  } spline_pt_t;

  typedef struct {
    bit          is_cfg;
    logic [0:0]  idx;
    logic [11:0] val;
    logic [23:0] x;
    logic [23:0] y;
    bit          typed;
    logic [23:0] tx;
    logic [23:0] ty;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = crst_pkg::RegTotal;
  logic [11:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  catmull_rom_spline_tessellator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [11:0]        total_reg = 12'd64;
  logic [8:0]         count_reg = 9'd4;
  logic signed [23:0] win_x [3];
  logic signed [23:0] win_y [3];
  int unsigned        pts_seen, budget, share;

  spline_pt_t expected_pts [$];
  int errors, n_items, n_points, n_clamped, burst_left;
  stim_row_t dir_rows [$];

  function automatic int unsigned live_count();
    if (count_reg < 4) return 4;
    if (count_reg > 256) return 256;
    return count_reg;
  endfunction

  function automatic longint round_away(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [23:0] q24_to_q8(longint s);
    longint r;
    r = (s + 32768) >>> 16;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[23:0];
  endfunction

  task automatic predict_segment(logic [23:0] cx, logic [23:0] cy,
                                 bit typed, logic [23:0] tx, logic [23:0] ty);
    int unsigned n;
    bit clip;
    longint px [4], py [4], num [4], nn, den, kk, w, sx, sy;
    spline_pt_t p;
    if (pts_seen == 0) begin
      budget = total_reg;
      share = total_reg / (live_count() - 3);
    end
    if (pts_seen >= 3) begin
      clip = 0;
      if (2 * share > budget) begin
        n = budget;
      end else begin
        n = share;
        budget = budget - share;
      end
      if (n > crst_pkg::MaxSegPoints) begin
        n = crst_pkg::MaxSegPoints;
        clip = 1;
      end
      for (int j = 0; j < 3; j++) begin
        px[j] = longint'(win_x[j]);
        py[j] = longint'(win_y[j]);
      end
      px[3] = longint'($signed(cx));
      py[3] = longint'($signed(cy));
      nn = n;
      den = 2 * nn * nn * nn;
      for (int k = 0; k < n; k++) begin
        kk = k;
        num[0] = -kk*kk*kk + 2*kk*kk*nn - kk*nn*nn;
        num[1] = 3*kk*kk*kk - 5*kk*kk*nn + 2*nn*nn*nn;
        num[2] = -3*kk*kk*kk + 4*kk*kk*nn + kk*nn*nn;
        num[3] = kk*kk*kk - kk*kk*nn;
        sx = 0;
        sy = 0;
        for (int j = 0; j < 4; j++) begin
          w = round_away(num[j] * 65536, den);
          sx += w * px[j];
          sy += w * py[j];
        end
        p.x = q24_to_q8(sx);
        p.y = q24_to_q8(sy);
        if (typed && k == 0) begin
          p.x = tx;
          p.y = ty;
        end
        p.seg = 8'(pts_seen - 3);
        p.last = (k == n - 1);
        p.clamp = clip;
        expected_pts.push_back(p);
      end
    end
    win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = cx;
    win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = cy;
    pts_seen = (pts_seen + 1) & 9'h1FF;
    if (pts_seen >= live_count()) pts_seen = 0;
  endtask

  task automatic send_point(logic [23:0] x, logic [23:0] y,
                            bit typed = 0, logic [23:0] tx = '0, logic [23:0] ty = '0);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_segment(x, y, typed, tx, ty);
    n_items++;
  endtask

  // drain outstanding points, then write a register
  task automatic write_reg(logic [0:0] idx, logic [11:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_pts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == crst_pkg::RegTotal) total_reg = val;
    else count_reg = val[8:0];
  endtask

  function automatic stim_row_t row_cfg(logic [0:0] idx, logic [11:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic stim_row_t row_pt(logic [23:0] x, logic [23:0] y,
                                       bit typed = 0, logic [23:0] tx = '0,
                                       logic [23:0] ty = '0);
    stim_row_t r;
    r = '{default: '0};
    r.x = x; r.y = y; r.typed = typed; r.tx = tx; r.ty = ty;
    return r;
  endfunction

  // output checker
  always @(posedge clk_i) begin
    spline_pt_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pts.size() == 0) begin
        $error("unexpected output transfer x=%h y=%h", m_axis_tdata[23:0],
               m_axis_tdata[47:24]);
        errors++;
      end else begin
        e = expected_pts.pop_front();
        n_points++;
        if (m_axis_tuser) n_clamped++;
        if (m_axis_tdata[23:0] !== e.x) begin
          $error("out_x expected %h got %h", e.x, m_axis_tdata[23:0]);
          errors++;
        end
        if (m_axis_tdata[47:24] !== e.y) begin
          $error("out_y expected %h got %h", e.y, m_axis_tdata[47:24]);
          errors++;
        end
        if (m_axis_tdata[55:48] !== e.seg) begin
          $error("segment_index expected %0d got %0d", e.seg, m_axis_tdata[55:48]);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last_of_segment expected %b got %b", e.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== e.clamp) begin
          $error("clamped expected %b got %b", e.clamp, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // receiver: own stall pattern, one long hold-off while input is offered
  initial begin
    int cyc, mode;
    bit held;
    cyc = 0;
    mode = 0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (!held && cyc >= 1500 && s_axis_tvalid) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end
      if (cyc % 200 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [23:0] x, y;
    int unsigned tp, cp;
    for (int j = 0; j < 3; j++) begin
      win_x[j] = '0;
      win_y[j] = '0;
    end
    pts_seen = 0;
    budget = 64;
    share = 64;
    burst_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset budget, extremes; then clamp, empty, budget rule, long curve
    dir_rows.push_back(row_pt(24'h000000, 24'h000000));
    dir_rows.push_back(row_pt(24'h000100, 24'h000200));
    dir_rows.push_back(row_pt(24'h7FFFFF, 24'h800000));
    dir_rows.push_back(row_pt(24'h800000, 24'h7FFFFF, 1, 24'h000100, 24'h000200));
    dir_rows.push_back(row_cfg(crst_pkg::RegTotal, 12'd4095));
    dir_rows.push_back(row_cfg(crst_pkg::RegCount, 12'd0));
    dir_rows.push_back(row_pt(24'h800000, 24'h800000));
    dir_rows.push_back(row_pt(24'h7FFFFF, 24'h7FFFFF));
    dir_rows.push_back(row_pt(24'h7FFFFF, 24'h7FFFFF));
    dir_rows.push_back(row_pt(24'h800000, 24'h800000, 1, 24'h7FFFFF, 24'h7FFFFF));
    dir_rows.push_back(row_cfg(crst_pkg::RegTotal, 12'd0));
    for (int i = 0; i < 4; i++) dir_rows.push_back(row_pt(24'h001234, 24'hFFEDCC));
    dir_rows.push_back(row_cfg(crst_pkg::RegTotal, 12'd7));
    dir_rows.push_back(row_cfg(crst_pkg::RegCount, 12'd6));
    for (int i = 0; i < 6; i++) dir_rows.push_back(row_pt(24'(i * 300), 24'(-i * 77)));
    dir_rows.push_back(row_cfg(crst_pkg::RegCount, 12'h1FF));
    for (int i = 0; i < 5; i++) dir_rows.push_back(row_pt(24'(i * 9), 24'(i * 5)));
    dir_rows.push_back(row_cfg(crst_pkg::RegCount, 12'd5));
    dir_rows.push_back(row_pt(24'h000010, 24'h000020));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].val);
      else send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed,
                      dir_rows[i].tx, dir_rows[i].ty);
    end

    for (int ph = 0; ph < 7; ph++) begin
      tp = $urandom_range(0, 160);
      cp = $urandom_range(4, 12);
      if (ph == 2) begin
        tp = 4095;
        cp = 4;
      end
      if (ph == 4) cp = $urandom_range(0, 3);
      if (ph == 5) cp = $urandom_range(300, 511);
      write_reg(crst_pkg::RegTotal, 12'(tp));
      write_reg(crst_pkg::RegCount, 12'(cp));
      repeat (38) begin
        if ($urandom_range(0, 3) == 0) begin
          x = 24'($signed($urandom_range(0, 4000)) - 2000);
          y = 24'($signed($urandom_range(0, 4000)) - 2000);
        end else begin
          x = 24'($urandom);
          y = 24'($urandom);
        end
        send_point(x, y);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_pts.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d control points, checked %0d curve points (%0d clamped).",
             n_items, n_points, n_clamped);
    $display("Budgets from 0 to 4095, counts below 4 up to 511, stalled output.");
    if (errors == 0 && expected_pts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/crst_pkg.sv
hw/rtl/crst_ctrl.sv
hw/rtl/crst_dp.sv
hw/rtl/catmull_rom_spline_tessellator.sv
verif/tb_top.sv
